@@ design/bfa_pkg.sv @@
// bitmap frame allocator package: sizes, op codes, controller/datapath structs
// no dependencies
`default_nettype none
package bfa_pkg;
  localparam int FRAMES      = 1048576;
  localparam int FRAME_BYTES = 4096;
  localparam int FB_SHIFT    = $clog2(FRAME_BYTES);
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int CUR_W       = FRAME_W + 1;
  localparam int WORDS       = (FRAMES + 31) / 32;
  localparam int WORD_AW     = $clog2(WORDS);
  localparam int FREE_W      = 21;
  localparam int SPAN_W      = 32 - FB_SHIFT + 1;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 56;

  localparam logic [1:0] OP_REL_REGION = 2'd0;
  localparam logic [1:0] OP_ALLOC      = 2'd1;
  localparam logic [1:0] OP_REL_FRAME  = 2'd2;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic ev;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

@@ design/bfa_ctrl.sv @@
// bitmap frame allocator controller: clear pass, word read/evaluate loop, result push
// depends on bfa_pkg
`default_nettype none
module bfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_t      cmd_o
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EV, S_OUT} state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      case (state_q)
        S_CLR:  if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE: if (in_valid_i) state_q <= S_RD;
        S_RD:   state_q <= S_EV;
        S_EV:   state_q <= sts_i.done ? S_OUT : S_RD;
        S_OUT:  if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    cmd_o.clr  = (state_q == S_CLR);
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd   = (state_q == S_RD);
    cmd_o.ev   = (state_q == S_EV);
    cmd_o.push = (state_q == S_OUT) && sts_i.out_free;
  end
endmodule
`default_nettype wire

@@ design/bfa_dp.sv @@
// bitmap frame allocator datapath: bitmap memory, scan/release word logic, counters
// depends on bfa_pkg
`default_nettype none
module bfa_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bfa_pkg::cmd_t               cmd_i,
  output bfa_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [31:0]                 addr_i,
  input  wire logic [31:0]                 size_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [31:0]                      out_addr_o,
  output logic                             out_ok_o,
  output logic [bfa_pkg::FREE_W-1:0]       out_free_o
);
  localparam int CW = bfa_pkg::CUR_W;
  localparam logic [CW-1:0] FR = CW'(bfa_pkg::FRAMES);

  logic [31:0] mem_q [bfa_pkg::WORDS];
  logic [31:0] rd_q;
  logic [bfa_pkg::WORD_AW-1:0] clr_q;
  logic [1:0]  op_q;
  logic [CW-1:0] cur_q, cur_d, end_q, end_d;
  logic        pass_q, pass_d;
  logic [bfa_pkg::FRAME_W-1:0] ptr_q, ptr_d;
  logic [bfa_pkg::FREE_W-1:0]  free_q, free_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic        res_ok_q, res_ok_d;
  logic        done;
  logic        wr_en;
  logic [31:0] wr_data;

  logic [bfa_pkg::SPAN_W-1:0] st_f, en_f;
  logic [bfa_pkg::WORD_AW-1:0] wi;
  logic [CW-1:0] wbase, wnext, endm1;
  logic [4:0]  lo, hi, idx;
  logic [31:0] mask, avail;
  logic        found;
  logic [5:0]  cnt;
  logic [bfa_pkg::FREE_W:0] fsum;

  assign wi    = cur_q[bfa_pkg::WORD_AW+4:5];
  assign wbase = {cur_q[CW-1:5], 5'd0};
  assign wnext = wbase + CW'(32);
  assign endm1 = end_q - CW'(1);
  assign lo    = cur_q[4:0];
  assign hi    = (end_q >= wnext) ? 5'd31 : endm1[4:0];
  assign cnt   = 6'(hi) - 6'(lo) + 6'd1;
  assign fsum  = (bfa_pkg::FREE_W+1)'(free_q) + (bfa_pkg::FREE_W+1)'(cnt);

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      mask[b]  = (5'(b) >= lo) && (5'(b) <= hi);
      avail[b] = !rd_q[b] && (5'(b) >= lo) && ((wbase + CW'(b)) < FR);
    end
    found = |avail;
    idx = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (avail[b]) idx = 5'(b);
    end
  end

  always_comb begin
    st_f = bfa_pkg::SPAN_W'(addr_i >> bfa_pkg::FB_SHIFT);
    en_f = st_f + bfa_pkg::SPAN_W'(size_i >> bfa_pkg::FB_SHIFT);
  end

  always_comb begin
    cur_d = cur_q; end_d = end_q; pass_d = pass_q; ptr_d = ptr_q; free_d = free_q;
    res_addr_d = res_addr_q; res_ok_d = res_ok_q;
    done = 1'b0; wr_en = 1'b0; wr_data = rd_q;
    if (cmd_i.load) begin
      pass_d = 1'b0; res_addr_d = '0; res_ok_d = 1'b0;
      case (op_i)
        bfa_pkg::OP_REL_REGION: begin
          res_ok_d = 1'b1;
          if (st_f >= bfa_pkg::SPAN_W'(bfa_pkg::FRAMES)) begin
            cur_d = FR; end_d = FR;
          end else begin
            cur_d = CW'(st_f);
            end_d = (en_f > bfa_pkg::SPAN_W'(bfa_pkg::FRAMES)) ? FR : CW'(en_f);
          end
        end
        bfa_pkg::OP_ALLOC: begin
          cur_d = CW'(ptr_q); end_d = FR;
        end
        bfa_pkg::OP_REL_FRAME: begin
          if (st_f < bfa_pkg::SPAN_W'(bfa_pkg::FRAMES)) begin
            cur_d = CW'(st_f); end_d = CW'(st_f) + CW'(1); res_ok_d = 1'b1;
          end else begin
            cur_d = FR; end_d = FR;
          end
        end
        default: begin
          cur_d = FR; end_d = FR;
        end
      endcase
    end else if (cmd_i.ev) begin
      if (op_q == bfa_pkg::OP_ALLOC) begin
        if (cur_q >= FR) begin
          ptr_d = '0;
          if (!pass_q) begin
            pass_d = 1'b1; cur_d = '0;
          end else begin
            done = 1'b1; res_ok_d = 1'b0;
          end
        end else if (found) begin
          wr_en = 1'b1;
          wr_data = rd_q | (32'd1 << idx);
          ptr_d = bfa_pkg::FRAME_W'(wbase + CW'(idx));
          if (free_q != '0) free_d = free_q - 1'b1;
          res_addr_d = 32'(wbase + CW'(idx)) << bfa_pkg::FB_SHIFT;
          res_ok_d = 1'b1;
          done = 1'b1;
        end else begin
          cur_d = wnext;
        end
      end else if (cur_q >= end_q) begin
        done = 1'b1;
      end else begin
        wr_en = 1'b1;
        wr_data = rd_q & ~mask;
        free_d = (fsum > (bfa_pkg::FREE_W+1)'(bfa_pkg::FRAMES)) ?
                 bfa_pkg::FREE_W'(bfa_pkg::FRAMES) : bfa_pkg::FREE_W'(fsum);
        cur_d = wnext;
        done = (wnext >= end_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mem_q[clr_q] <= '1;
    else if (wr_en) mem_q[wi] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[wi];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) op_q <= op_i;
    cur_q <= cur_d; end_q <= end_d; pass_q <= pass_d;
    res_addr_q <= res_addr_d; res_ok_q <= res_ok_d;
    if (cmd_i.push) begin
      out_addr_o <= res_addr_q; out_ok_o <= res_ok_q; out_free_o <= free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      ptr_q <= bfa_pkg::FRAME_W'(1);
      free_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      ptr_q <= ptr_d;
      free_q <= free_d;
      if (cmd_i.push) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  assign sts_o.clr_last = (clr_q == bfa_pkg::WORD_AW'(bfa_pkg::WORDS - 1));
  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_o || out_ready_i;
endmodule
`default_nettype wire

@@ design/bitmap_frame_allocator.sv @@
// bitmap frame allocator top level: stream ports around controller and datapath
// depends on bfa_pkg, bfa_ctrl, bfa_dp
//
// channel   dir  fields (tdata, lsb first)
// s_axis    in   operation[1:0], address[33:2], region_size[65:34], zero pad to 72
// m_axis    out  frame_address[31:0], ok[32], free_count[53:33], zero pad to 56
//
// each item runs a memory read, then evaluate and write back, for each bitmap word
// it visits, plus a step to accept it and a step to hand off the result
// an item that touches no word still spends one read/evaluate pair, and allocate
// spends one more pair each time a pass runs off the end of the map
// after reset a clearing pass sets every bitmap word, one word per cycle, before
// the first item is taken
// a result waits in the output register; the next item is taken once it is queued
`default_nettype none
module bitmap_frame_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [bfa_pkg::IN_W-1:0]  s_axis_tdata_i,  // operation, address, region_size
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [bfa_pkg::OUT_W-1:0]      m_axis_tdata_o   // frame_address, ok, free_count
);
  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;
  logic [31:0] faddr;
  logic        ok;
  logic [bfa_pkg::FREE_W-1:0] fcnt;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tdata_i[1:0]),
    .addr_i      (s_axis_tdata_i[33:2]),
    .size_i      (s_axis_tdata_i[65:34]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_addr_o  (faddr),
    .out_ok_o    (ok),
    .out_free_o  (fcnt)
  );

  assign m_axis_tdata_o = {2'b00, fcnt, ok, faddr};
endmodule
`default_nettype wire
